@@ hdl/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is active
`define MBPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define MBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// Types, register indexes and helpers of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 8;
    localparam int PATTERN_W             = 64;
    localparam int MASK_W                = 8;
    localparam int LEN_W                 = 4;
    localparam int ADDR_W                = 64;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MUST_MATCH_MASK = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_MODE    = 3'd4;

    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 4'd1;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [MASK_W-1:0]    must_match_mask;
        logic [LEN_W-1:0]     pattern_length;
        logic [ADDR_W-1:0]    base_address;
        logic                 reverse_mode;
    } cfg_t;

    // length clamped to 1..max_bytes
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len,
                                                    input int max_bytes);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(max_bytes);
        if (len == '0) begin
            return PATTERN_LENGTH_RESET;
        end else if (len > lim) begin
            return lim;
        end
        return len;
    endfunction

endpackage

@@ hdl/mbps_cfg.sv @@
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mbps_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output mbps_pkg::cfg_t                  cfg
);
    import mbps_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_bytes   <= '0;
            cfg_reg.must_match_mask <= '0;
            cfg_reg.pattern_length  <= PATTERN_LENGTH_RESET;
            cfg_reg.base_address    <= '0;
            cfg_reg.reverse_mode    <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_PATTERN_BYTES:   cfg_reg.pattern_bytes   <= cfg_wdata[PATTERN_W-1:0];
                REG_MUST_MATCH_MASK: cfg_reg.must_match_mask <= cfg_wdata[MASK_W-1:0];
                REG_PATTERN_LENGTH:  cfg_reg.pattern_length  <= cfg_wdata[LEN_W-1:0];
                REG_BASE_ADDRESS:    cfg_reg.base_address    <= cfg_wdata[ADDR_W-1:0];
                REG_REVERSE_MODE:    cfg_reg.reverse_mode    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/mbps_match.sv @@
// ----------------------------------------------------------------------------
// mbps_match
// Sliding byte window and parallel masked compare against the pattern.
// ----------------------------------------------------------------------------
module mbps_match #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  mbps_pkg::cfg_t cfg,
    input  logic           advance,
    input  logic           last,
    input  logic [7:0]     data_byte,
    output logic           hit
);
    import mbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [7:0]       win_reg [MAX_PATTERN_BYTES];
    logic [7:0]       win_new [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0] len;

    // window including the byte being processed, entry 0 the newest
    always_comb begin
        win_new[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            win_new[k] = win_reg[k-1];
        end
    end

    assign len = eff_length(cfg.pattern_length, MAX_PATTERN_BYTES);

    always_comb begin
        logic [LEN_W-1:0] age;
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            age = len - 4'd1 - LEN_W'(i);
            if ((LEN_W'(i) < len) && cfg.must_match_mask[i] &&
                (win_new[age[IDX_W-1:0]] != cfg.pattern_bytes[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                win_reg[k] <= '0;
            end
        end else if (advance) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                win_reg[k] <= last ? 8'd0 : win_new[k];
            end
        end
    end

endmodule

@@ hdl/mbps_track.sv @@
// ----------------------------------------------------------------------------
// mbps_track
// Position and hit tracking per range, and the result register.
// ----------------------------------------------------------------------------
module mbps_track #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mbps_pkg::cfg_t             cfg,
    input  logic                       advance,
    input  logic                       last,
    input  logic                       hit,
    output logic                       out_free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mbps_pkg::ADDR_W-1:0] m_tdata,  // match_address
    output logic [0:0]                 m_tuser   // found
);
    import mbps_pkg::*;

    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic              seen_reg, seen_next;
    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic              m_found_reg;
    logic [LEN_W-1:0]  len_m1;
    logic [ADDR_W-1:0] cand;
    logic              take;

    assign len_m1 = eff_length(cfg.pattern_length, MAX_PATTERN_BYTES) - 4'd1;
    assign cand   = pos_reg - {{(ADDR_W-LEN_W){1'b0}}, len_m1};
    assign take   = hit && ((pos_reg + 64'd1) > {{(ADDR_W-LEN_W){1'b0}}, len_m1});

    always_comb begin
        pos_next  = pos_reg + 64'd1;
        seen_next = seen_reg | take;
        off_next  = (take && (cfg.reverse_mode || !seen_reg)) ? cand : off_reg;
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            off_reg  <= '0;
            seen_reg <= 1'b0;
        end else if (advance) begin
            if (last) begin
                pos_reg  <= '0;
                off_reg  <= '0;
                seen_reg <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                off_reg  <= off_next;
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last) begin
            m_found_reg <= seen_next;
            m_addr_reg  <= seen_next ? (cfg.base_address + off_next) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_found_reg;

endmodule

@@ hdl/masked_byte_pattern_scan.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Wildcard byte signature scan over a streamed address range.
//
// The range arrives one byte per transaction on the s_ channel, s_tlast on
// its final byte. Configuration (pattern, must-match mask, length, base
// address, direction) is written through cfg_wen / cfg_index / cfg_wdata.
// Every start position is compared as soon as its last byte arrives.
// For each range one result transaction leaves on the m_ channel:
// m_tuser is the found flag, m_tdata the match address (0 if none).
// Throughput: one byte per cycle, set by the combinational masked compare,
// while no s_tlast byte is held. A result's s_tlast byte is accepted into
// the input register, then the compare loads the result register.
// While a result waits for m_tready, bytes of the next range keep flowing;
// only the next s_tlast byte is held until the result register is free.
// Reset (aresetn low, synchronous) clears range state, drops m_tvalid and
// restores the register defaults (length 1, all others zero).
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tlast,   // end_of_range
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mbps_pkg::ADDR_W-1:0]      m_tdata,   // match_address
    output logic [0:0]                       m_tuser    // found
);
    import mbps_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       out_free;
    logic       hit;

    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (advance),
        .last      (in_last_reg),
        .data_byte (in_byte_reg),
        .hit       (hit)
    );

    mbps_track #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .advance  (advance),
        .last     (in_last_reg),
        .hit      (hit),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ hdl/mbps_checker.sv @@
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte pattern scanner, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbps_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wen,
    input logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mbps_pkg::ADDR_W-1:0]      m_tdata,
    input logic [0:0]                       m_tuser
);

    // no address without a match
    `MBPS_ASSERT(a_no_addr_when_not_found, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "address set on a result without a match")

    // stalled result holds
    `MBPS_ASSERT(a_result_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

    // a fresh result follows an accepted last-byte transaction
    `MBPS_ASSERT(a_result_after_last, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2), "result without a preceding last byte")

    // reset drops the result channel
    `MBPS_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (.*);
